// ===== rtl/kvt_pkg.sv =====
// kvt_pkg: shared types and constants of the key/value table.
// Used by the channel interfaces, the table top level and its checker.
`timescale 1ns / 1ps
package kvt_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int MODE_W       = 2;
   localparam int KEY_W        = 64;
   localparam int VALUE_W      = 64;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_UPDATE = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_DUP       = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

// ===== rtl/kvt_if.sv =====
// kvt_req_if / kvt_rsp_if: valid/ready channels of the key/value table.
// Depends on kvt_pkg for field widths.
`timescale 1ns / 1ps
interface kvt_req_if;
   import kvt_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
   import kvt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [VALUE_W-1:0]     read_value;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output read_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input entry_count,
                   output ready);
endinterface

// ===== rtl/kvt_ram.sv =====
// kvt_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module kvt_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== rtl/key_value_table_top.sv =====
// key_value_table_top: associative key/value table with unique keys.
// Depends on kvt_pkg, kvt_req_if / kvt_rsp_if and kvt_ram.
//
//   channel   | dir | transaction payload                       | handshake
//   ----------+-----+-------------------------------------------+-------------
//   req_bus   | in  | mode, key, value                          | valid/ready
//   rsp_bus   | out | status, read_value, entry_count           | valid/ready
//
// Sequence: each request passes through an accept state, a scan state that
//   streams the key and value memories through the comparator, a drain
//   state and a commit state. The serial scan over the single read port of
//   the key memory dominates the time a request takes.
// Reset: synchronous; clears valid marks, entry count and handshake state.
//   The memories are not cleared; an entry is only used once its mark is set.
// Stalls: a finished response waits in the output register; the next request
//   is taken meanwhile and only its commit waits for the register to drain.
`timescale 1ns / 1ps
module key_value_table_top #(
   parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   kvt_req_if.sink   req_bus,
   kvt_rsp_if.source rsp_bus
);
   import kvt_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_type;

   state_type            state_ff;
   mode_type             mode_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [IDX_W-1:0]     scan_ff;
   logic                 cmp_vld_ff;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     hit_idx_ff;
   logic [VALUE_W-1:0]   hit_val_ff;
   logic                 free_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic [CAPACITY-1:0]  valid_ff;
   logic [CNT_W-1:0]     count_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   // memory ports
   logic [KEY_W-1:0]     key_rd;
   logic [VALUE_W-1:0]   val_rd;
   logic                 key_we;
   logic                 val_we;
   logic [IDX_W-1:0]     val_waddr;
   logic                 rd_en;

   // compare stage and commit decision
   logic                 cmp_hit;
   logic                 cmp_free;
   logic                 commit_go;
   logic                 do_insert;
   logic                 do_remove;
   logic                 do_update;
   status_type           status_in;
   logic [VALUE_W-1:0]   read_value_in;
   logic [CNT_W-1:0]     count_in;

   kvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY), .ADDR_W(IDX_W)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (key_rd)
   );

   kvt_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY), .ADDR_W(IDX_W)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (val_rd)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.read_value  = rsp_value_ff;
   assign rsp_bus.entry_count = rsp_count_ff;

   assign rd_en = (state_ff == S_SCAN);

   // Entry read last cycle; valid marks do not move during a scan.
   assign cmp_hit  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (key_rd == key_ff);
   assign cmp_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];

   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      do_update     = 1'b0;
      status_in     = ST_OK;
      read_value_in = '0;
      case (mode_ff)
         MODE_INSERT: begin
            // duplicate check wins over the full check
            if (hit_ff) begin
               status_in = ST_DUP;
            end else if (!free_ff) begin
               status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (hit_ff) begin
               do_remove = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         MODE_LOOKUP: begin
            if (hit_ff) begin
               read_value_in = hit_val_ff;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         MODE_UPDATE: begin
            if (hit_ff) begin
               do_update = 1'b1;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_NOT_FOUND;
         end
      endcase

      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign key_we    = commit_go && do_insert;
   assign val_we    = commit_go && (do_insert || do_update);
   assign val_waddr = do_insert ? free_idx_ff : hit_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a commit in the same cycle reloads the register instead
         if (rsp_valid_ff && rsp_bus.ready && !commit_go) begin
            rsp_valid_ff <= 1'b0;
         end

         // keys are unique, so at most one hit per scan
         if (cmp_hit && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
            hit_val_ff <= val_rd;
         end
         if (cmp_free && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  mode_ff  <= mode_type'(req_bus.mode);
                  key_ff   <= req_bus.key;
                  value_ff <= req_bus.value;
                  hit_ff   <= 1'b0;
                  free_ff  <= 1'b0;
                  scan_ff  <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= scan_ff;
               if (scan_ff == LAST_IDX) begin
                  state_ff <= S_DRAIN;
               end else begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
            end
            S_DRAIN: begin
               cmp_vld_ff <= 1'b0;
               state_ff   <= S_COMMIT;
            end
            S_COMMIT: begin
               if (commit_go) begin
                  if (do_insert) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                  end
                  if (do_remove) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                  end
                  count_ff      <= count_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_in;
                  rsp_value_ff  <= read_value_in;
                  rsp_count_ff  <= COUNT_OUT_W'(count_in);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

// ===== rtl/kvt_checker.sv =====
// kvt_checker: port-level assertions for key_value_table_top, with its bind.
// Depends on kvt_pkg.
`timescale 1ns / 1ps
module kvt_checker #(
   parameter int CAPACITY = kvt_pkg::DEF_CAPACITY
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [kvt_pkg::STATUS_W-1:0]      rsp_status,
   input logic [kvt_pkg::VALUE_W-1:0]       rsp_read_value,
   input logic [kvt_pkg::COUNT_OUT_W-1:0]   rsp_entry_count
);
   import kvt_pkg::*;

   localparam logic [COUNT_OUT_W-1:0] CAP_COUNT = COUNT_OUT_W'(CAPACITY);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // only a successful lookup returns data
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |-> rsp_status == ST_OK)
      else $error("read_value set on a failed transaction");

   // a full answer means every slot is in use
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == CAP_COUNT)
      else $error("full reported below capacity");

   // the count never exceeds capacity (when it fits in the field)
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (CAPACITY < 32) |-> rsp_entry_count <= CAP_COUNT)
      else $error("entry_count above capacity");
endmodule

bind key_value_table_top kvt_checker #(.CAPACITY(CAPACITY)) u_kvt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_read_value  (rsp_bus.read_value),
   .rsp_entry_count (rsp_bus.entry_count)
);

// ===== sim/key_value_table_top_tb.sv =====
// Self-checking testbench of key_value_table_top: directed and random requests against
// an in-bench table predictor, with random idling and one long response hold-off.
// Depends on kvt_pkg, kvt_req_if / kvt_rsp_if and the key_value_table_top RTL.
`timescale 1ns / 1ps
module key_value_table_top_tb;
   import kvt_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int RANDOM_ITEMS = 1000;
   localparam int POOL_MAX     = 24;          // above CAPACITY so fill bursts hit full
   localparam int DRAIN_CYCLES = 3 * (CAPACITY + 3);
   localparam int HOLD_AT      = 800;         // response count that starts the hold-off
   localparam int HOLD_CYCLES  = 200;
   localparam int REPORT_MAX   = 60;

   typedef struct packed {
      mode_type            mode;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } kv_request_type;

   typedef struct packed {
      status_type               status;
      logic [VALUE_W-1:0]       read_value;
      logic [COUNT_OUT_W-1:0]   entry_count;
   } kv_result_type;

   logic clock = 1'b0;
   logic reset;

   kvt_req_if req_bus ();
   kvt_rsp_if rsp_bus ();

   key_value_table_top #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Requests waiting to be offered, and results still owed by the table.
   kv_request_type pending_requests [$];
   kv_result_type  expected_results [$];

   // Predictor copy of the table.
   logic [KEY_W-1:0]   table_keys   [CAPACITY];
   logic [VALUE_W-1:0] table_values [CAPACITY];
   logic               table_valid  [CAPACITY];
   int                 table_count;

   int accepted_count = 0;
   int result_count   = 0;
   int error_count    = 0;
   int report_count   = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int mode_seen   [4];
   int status_seen [4];

   // Apply one request to the predictor table and return the result it owes.
   function automatic kv_result_type table_apply(kv_request_type r);
      kv_result_type res;
      int hit;
      int slot;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit < 0 && table_valid[i] && table_keys[i] == r.key)
            hit = i;
         if (slot < 0 && !table_valid[i])
            slot = i;
      end
      res.status     = ST_OK;
      res.read_value = '0;
      case (r.mode)
         MODE_INSERT: begin
            // duplicate check wins over full check
            if (hit >= 0)
               res.status = ST_DUP;
            else if (slot < 0)
               res.status = ST_FULL;
            else begin
               table_keys[slot]   = r.key;
               table_values[slot] = r.value;
               table_valid[slot]  = 1'b1;
               table_count++;
            end
         end
         MODE_REMOVE: begin
            if (hit >= 0) begin
               table_valid[hit] = 1'b0;
               table_count--;
            end else
               res.status = ST_NOT_FOUND;
         end
         MODE_LOOKUP: begin
            if (hit >= 0)
               res.read_value = table_values[hit];
            else
               res.status = ST_NOT_FOUND;
         end
         default: begin
            if (hit >= 0)
               table_values[hit] = r.value;
            else
               res.status = ST_NOT_FOUND;
         end
      endcase
      res.entry_count = COUNT_OUT_W'(table_count);
      mode_seen[int'(r.mode)]++;
      status_seen[int'(res.status)]++;
      return res;
   endfunction

   // Idle percentages follow progress: sender-light, then receiver-light, then none.
   function automatic int tx_idle_pct();
      if (accepted_count < (RANDOM_ITEMS + 26) / 3)
         return 29;
      else if (accepted_count < 2 * (RANDOM_ITEMS + 26) / 3)
         return 51;
      return 0;
   endfunction

   function automatic int rx_idle_pct();
      if (accepted_count < (RANDOM_ITEMS + 26) / 3)
         return 51;
      else if (accepted_count < 2 * (RANDOM_ITEMS + 26) / 3)
         return 29;
      return 0;
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic add_request(mode_type m, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      kv_request_type r;
      r.mode  = m;
      r.key   = k;
      r.value = v;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      error_count++;
      report_count++;
      if (report_count <= REPORT_MAX)
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      else if (report_count == REPORT_MAX + 1)
         $display("%0t ns: further mismatch reports suppressed", $time);
   endtask

   // Request driver: a transaction completes on valid && ready; the prediction is
   // taken at that edge so the model sees requests in the order the table does.
   always @(posedge clock) begin : drive_requests
      logic offer;
      kv_result_type predicted;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = table_apply(pending_requests[0]);
            expected_results.insert(expected_results.size(), predicted);
            void'(pending_requests.pop_front());
            accepted_count++;
         end
         // an offered request stays up until taken
         if (req_bus.valid && !req_bus.ready)
            offer = 1'b1;
         else
            offer = (pending_requests.size() != 0) && ($urandom_range(99) >= tx_idle_pct());
         req_bus.valid <= offer;
         if (offer) begin
            req_bus.mode  <= pending_requests[0].mode;
            req_bus.key   <= pending_requests[0].key;
            req_bus.value <= pending_requests[0].value;
         end
      end
   end

   // Response monitor and ready generator, including the one long hold-off that
   // lets the table fill its output register and back-pressure the request side.
   always @(posedge clock) begin : check_responses
      kv_result_type want;
      logic next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t ns: response with no request outstanding, actual %0d/%h/%0d",
                        $time, rsp_bus.status, rsp_bus.read_value, rsp_bus.entry_count);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 64'(want.status), 64'(rsp_bus.status));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch("read_value", want.read_value, rsp_bus.read_value);
               if (rsp_bus.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 64'(want.entry_count),
                                  64'(rsp_bus.entry_count));
            end
            if (result_count == HOLD_AT && !hold_done) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else
            next_ready = ($urandom_range(99) >= rx_idle_pct());
         rsp_bus.ready <= next_ready;
      end
   end

   // Stimulus, reset and end of run.
   initial begin : run_sequence
      logic [KEY_W-1:0] key_pool [POOL_MAX];
      logic [KEY_W-1:0] k;
      logic [VALUE_W-1:0] v;
      mode_type m;
      int total_items;
      int random_added;
      int pool_size;
      int burst;
      int mix;
      int roll;
      int ins_pct;
      int rem_pct;
      int lkp_pct;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.mode   = MODE_INSERT;
      req_bus.key    = '0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      table_count    = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         table_valid[i]  = 1'b0;
         table_keys[i]   = '0;
         table_values[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         mode_seen[i]   = 0;
         status_seen[i] = 0;
      end

      // Directed: every operation with hit and miss, value extremes on a lookup.
      add_request(MODE_INSERT, '0, '0);
      add_request(MODE_INSERT, '0, '1);                  // duplicate key
      add_request(MODE_UPDATE, '0, '1);
      add_request(MODE_LOOKUP, '0, '0);                  // all-ones read back
      add_request(MODE_LOOKUP, 64'h1, '0);               // absent
      add_request(MODE_UPDATE, 64'h1, '1);               // absent
      add_request(MODE_REMOVE, '1, '0);                  // absent
      add_request(MODE_REMOVE, '0, '0);                  // empties the table
      // Fill every slot, then insert into a full table, then a duplicate on full.
      add_request(MODE_INSERT, '1, '1);
      for (int i = 0; i < CAPACITY - 1; i++)
         add_request(MODE_INSERT, 64'h1 << i, rand_word());
      add_request(MODE_INSERT, '0, '1);                  // full
      add_request(MODE_INSERT, '1, '0);                  // duplicate beats full

      // Random bursts: a fresh key pool per burst and a mix leaning toward fill,
      // drain or neither. Most keys hit the pool; some are near misses (one bit
      // flipped) or unrelated words.
      random_added = 0;
      while (random_added < RANDOM_ITEMS) begin
         pool_size = $urandom_range(POOL_MAX, 4);
         for (int i = 0; i < pool_size; i++) begin
            roll = $urandom_range(99);
            if (roll < 5)
               key_pool[i] = '0;
            else if (roll < 10)
               key_pool[i] = '1;
            else
               key_pool[i] = rand_word();
         end
         mix = $urandom_range(2);
         case (mix)
            0: begin ins_pct = 55; rem_pct = 10; lkp_pct = 20; end
            1: begin ins_pct = 15; rem_pct = 45; lkp_pct = 20; end
            default: begin ins_pct = 25; rem_pct = 25; lkp_pct = 25; end
         endcase
         burst = $urandom_range(60, 20);
         for (int n = 0; n < burst && random_added < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < ins_pct)
               m = MODE_INSERT;
            else if (roll < ins_pct + rem_pct)
               m = MODE_REMOVE;
            else if (roll < ins_pct + rem_pct + lkp_pct)
               m = MODE_LOOKUP;
            else
               m = MODE_UPDATE;
            roll = $urandom_range(99);
            k = key_pool[$urandom_range(pool_size - 1)];
            if (roll >= 93)
               k = rand_word();
            else if (roll >= 85)
               k = k ^ (64'h1 << $urandom_range(63));
            roll = $urandom_range(99);
            if (roll < 5)
               v = '0;
            else if (roll < 10)
               v = '1;
            else
               v = rand_word();
            add_request(m, k, v);
            random_added++;
         end
      end
      total_items = pending_requests.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: insert %0d, remove %0d, lookup %0d, update %0d",
               accepted_count, mode_seen[MODE_INSERT], mode_seen[MODE_REMOVE],
               mode_seen[MODE_LOOKUP], mode_seen[MODE_UPDATE]);
      $display("Outcomes: ok %0d, duplicate %0d, not found %0d, full %0d; errors %0d",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_NOT_FOUND],
               status_seen[ST_FULL], error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Run limit: far above the slowest legal run.
   initial begin : run_limit
      #5_000_000;
      $display("Timeout at %0t ns with %0d results outstanding", $time,
               expected_results.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/kvt_pkg.sv
rtl/kvt_if.sv
rtl/kvt_ram.sv
rtl/key_value_table_top.sv
rtl/kvt_checker.sv
sim/key_value_table_top_tb.sv
